### rtl/crsfr_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// crsfr_pkg
// Shared types and constants for the serial frame receiver.
// ----------------------------------------------------------------------------
package crsfr_pkg;

	localparam int BYTE_W = 8;
	localparam int CFG_IDX_W = 3;

	// configuration register indexes
	localparam logic [CFG_IDX_W-1:0] REG_ADDR_SYNC = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_ADDR_TX   = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_ADDR_RX   = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_MAX_LEN   = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_CRC_POLY  = 3'd4;
	localparam logic [CFG_IDX_W-1:0] REG_BATT_TYPE = 3'd5;
	localparam logic [CFG_IDX_W-1:0] REG_BARO_TYPE = 3'd6;
	localparam logic [CFG_IDX_W-1:0] REG_VARIO_TYPE = 3'd7;

	// reset values of the configuration registers
	localparam logic [BYTE_W-1:0] RST_ADDR_SYNC  = 8'd200;
	localparam logic [BYTE_W-1:0] RST_ADDR_TX    = 8'd234;
	localparam logic [BYTE_W-1:0] RST_ADDR_RX    = 8'd236;
	localparam logic [BYTE_W-1:0] RST_MAX_LEN    = 8'd64;
	localparam logic [BYTE_W-1:0] RST_CRC_POLY   = 8'd213;
	localparam logic [BYTE_W-1:0] RST_BATT_TYPE  = 8'd8;
	localparam logic [BYTE_W-1:0] RST_BARO_TYPE  = 8'd9;
	localparam logic [BYTE_W-1:0] RST_VARIO_TYPE = 8'd7;

	typedef struct packed {
		logic [BYTE_W-1:0] address_sync;
		logic [BYTE_W-1:0] address_transmitter;
		logic [BYTE_W-1:0] address_receiver;
		logic [BYTE_W-1:0] max_frame_length;
		logic [BYTE_W-1:0] crc_polynomial;
		logic [BYTE_W-1:0] battery_type_code;
		logic [BYTE_W-1:0] baro_type_code;
		logic [BYTE_W-1:0] vario_type_code;
	} cfg_t;

	typedef struct packed {
		logic              accepted;
		logic              frame_done;
		logic              crc_error;
		logic [BYTE_W-1:0] frame_type;
		logic [BYTE_W-1:0] frame_length;
		logic              battery_seen;
		logic              baro_seen;
	} result_t;

endpackage

### rtl/crsfr_cfg_regs.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// crsfr_cfg_regs
// Configuration register file written through a plain write port.
// ----------------------------------------------------------------------------
module crsfr_cfg_regs (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           cfg_we,
	input  logic [crsfr_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [crsfr_pkg::BYTE_W-1:0]    cfg_data,
	output crsfr_pkg::cfg_t                 cfg
);
	import crsfr_pkg::*;

	cfg_t cfg_q;

	// register writes, one register per index
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.address_sync        <= RST_ADDR_SYNC;
			cfg_q.address_transmitter <= RST_ADDR_TX;
			cfg_q.address_receiver    <= RST_ADDR_RX;
			cfg_q.max_frame_length    <= RST_MAX_LEN;
			cfg_q.crc_polynomial      <= RST_CRC_POLY;
			cfg_q.battery_type_code   <= RST_BATT_TYPE;
			cfg_q.baro_type_code      <= RST_BARO_TYPE;
			cfg_q.vario_type_code     <= RST_VARIO_TYPE;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_ADDR_SYNC:  cfg_q.address_sync        <= cfg_data;
				REG_ADDR_TX:    cfg_q.address_transmitter <= cfg_data;
				REG_ADDR_RX:    cfg_q.address_receiver    <= cfg_data;
				REG_MAX_LEN:    cfg_q.max_frame_length    <= cfg_data;
				REG_CRC_POLY:   cfg_q.crc_polynomial      <= cfg_data;
				REG_BATT_TYPE:  cfg_q.battery_type_code   <= cfg_data;
				REG_BARO_TYPE:  cfg_q.baro_type_code      <= cfg_data;
				REG_VARIO_TYPE: cfg_q.vario_type_code     <= cfg_data;
				default: ;
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule

### rtl/crsfr_crc8.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// crsfr_crc8
// Bytewise CRC8 update, MSB first, with a programmable polynomial.
// ----------------------------------------------------------------------------
module crsfr_crc8 (
	input  logic [crsfr_pkg::BYTE_W-1:0] crc_in,
	input  logic [crsfr_pkg::BYTE_W-1:0] data,
	input  logic [crsfr_pkg::BYTE_W-1:0] poly,
	output logic [crsfr_pkg::BYTE_W-1:0] crc_out
);
	import crsfr_pkg::*;

	// eight bit steps unrolled over one byte
	always_comb begin
		logic [BYTE_W-1:0] c;
		c = crc_in ^ data;
		for (int i = 0; i < BYTE_W; i++) begin
			if (c[BYTE_W-1]) begin
				c = {c[BYTE_W-2:0], 1'b0} ^ poly;
			end else begin
				c = {c[BYTE_W-2:0], 1'b0};
			end
		end
		crc_out = c;
	end

endmodule

### rtl/crsfr_parser.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// crsfr_parser
// Frame state machine: address, length and data phases, CRC check and
// sticky sensor flags. Produces one result per byte taken.
// ----------------------------------------------------------------------------
module crsfr_parser (
	input  logic                        clk,
	input  logic                        arst_n,
	input  crsfr_pkg::cfg_t             cfg,
	input  logic                        take,
	input  logic [crsfr_pkg::BYTE_W-1:0] rx_byte,
	input  logic                        from_serial,
	output crsfr_pkg::result_t          result
);
	import crsfr_pkg::*;

	localparam logic [1:0] PH_IDLE   = 2'd0;
	localparam logic [1:0] PH_LENGTH = 2'd1;
	localparam logic [1:0] PH_DATA   = 2'd2;

	logic [1:0]        phase_q, phase_d;
	logic [BYTE_W-1:0] len_q, len_d;
	logic [BYTE_W-1:0] count_q, count_d;
	logic [BYTE_W-1:0] crc_q, crc_d;
	logic [BYTE_W-1:0] type_q, type_d;
	logic              batt_q, batt_d;
	logic              baro_q, baro_d;
	logic [BYTE_W-1:0] crc_next;
	logic              acc, done, err;

	crsfr_crc8 u_crc8 (
		.crc_in  (crc_q),
		.data    (rx_byte),
		.poly    (cfg.crc_polynomial),
		.crc_out (crc_next)
	);

	// next state and result for the byte at the input
	always_comb begin
		phase_d = phase_q;
		len_d   = len_q;
		count_d = count_q;
		crc_d   = crc_q;
		type_d  = type_q;
		batt_d  = batt_q;
		baro_d  = baro_q;
		acc     = 1'b1;
		done    = 1'b0;
		err     = 1'b0;
		case (phase_q)
			PH_LENGTH: begin
				// zero length is rejected like an overlong one
				if (rx_byte >= cfg.max_frame_length || rx_byte == '0) begin
					phase_d = PH_IDLE;
					acc     = 1'b0;
				end else begin
					len_d   = rx_byte;
					phase_d = PH_DATA;
				end
			end
			PH_DATA: begin
				count_d = count_q + 1'b1;
				if (count_d == 8'd1) begin
					type_d = rx_byte;
				end
				if (count_d == len_q) begin
					// last byte carries the crc
					phase_d = PH_IDLE;
					if (rx_byte == crc_q) begin
						done = 1'b1;
						if (from_serial) begin
							if (type_d == cfg.battery_type_code) begin
								batt_d = 1'b1;
							end
							if (type_d == cfg.baro_type_code ||
							    type_d == cfg.vario_type_code) begin
								baro_d = 1'b1;
							end
						end
					end else begin
						err = 1'b1;
						acc = 1'b0;
					end
				end else begin
					crc_d = crc_next;
				end
			end
			default: begin
				// idle and the unused code look for a start address
				if (rx_byte == cfg.address_sync ||
				    rx_byte == cfg.address_transmitter ||
				    rx_byte == cfg.address_receiver) begin
					phase_d = PH_LENGTH;
					len_d   = '0;
					count_d = '0;
					crc_d   = '0;
					type_d  = '0;
				end else begin
					phase_d = PH_IDLE;
					acc     = 1'b0;
				end
			end
		endcase
	end

	// state registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_IDLE;
			len_q   <= '0;
			count_q <= '0;
			crc_q   <= '0;
			type_q  <= '0;
			batt_q  <= 1'b0;
			baro_q  <= 1'b0;
		end else if (take) begin
			phase_q <= phase_d;
			len_q   <= len_d;
			count_q <= count_d;
			crc_q   <= crc_d;
			type_q  <= type_d;
			batt_q  <= batt_d;
			baro_q  <= baro_d;
		end
	end

	// result fields show the state after the update
	always_comb begin
		result.accepted     = acc;
		result.frame_done   = done;
		result.crc_error    = err;
		result.frame_type   = type_d;
		result.frame_length = len_d;
		result.battery_seen = batt_d;
		result.baro_seen    = baro_d;
	end

endmodule

### rtl/crsfr_out_buf.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// crsfr_out_buf
// Result register with a skid stage, so a byte can be taken while the
// previous result still waits on the output.
// ----------------------------------------------------------------------------
module crsfr_out_buf (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               wr,
	input  crsfr_pkg::result_t wr_data,
	output logic               full,
	output logic               out_valid,
	input  logic               out_stall,
	output crsfr_pkg::result_t out_data
);
	import crsfr_pkg::*;

	result_t main_q, skid_q;
	logic    main_vld_q, skid_vld_q;
	logic    pop;
	logic    main_free;

	assign pop       = main_vld_q && !out_stall;
	assign main_free = !main_vld_q || pop;

	// valid flags
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			main_vld_q <= 1'b0;
			skid_vld_q <= 1'b0;
		end else begin
			if (main_free) begin
				main_vld_q <= skid_vld_q || wr;
				skid_vld_q <= skid_vld_q && wr;
			end else if (wr) begin
				skid_vld_q <= 1'b1;
			end
		end
	end

	// payload moves: skid drains first to keep order
	always_ff @(posedge clk) begin
		if (main_free) begin
			if (skid_vld_q) begin
				main_q <= skid_q;
				if (wr) begin
					skid_q <= wr_data;
				end
			end else if (wr) begin
				main_q <= wr_data;
			end
		end else if (wr) begin
			skid_q <= wr_data;
		end
	end

	assign full      = skid_vld_q;
	assign out_valid = main_vld_q;
	assign out_data  = main_q;

endmodule

### rtl/crsf_frame_receiver.sv
`timescale 1ns / 1ps
// Each result word is registered in the output buffer when its byte is accepted.
// Throughput: one byte per cycle unless in_stall; next state and CRC8 are combinational.
// A two-entry result buffer keeps the input open while one result waits on the output.
// Reset: arst_n clears the frame state, sensor flags and buffer; registers take defaults.
// ----------------------------------------------------------------------------
// crsf_frame_receiver
// Serial frame receiver: start address, length, payload with CRC8 check,
// and sticky battery and baro sensor flags.
// ----------------------------------------------------------------------------
module crsf_frame_receiver (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            cfg_we,
	input  logic [crsfr_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [crsfr_pkg::BYTE_W-1:0]    cfg_data,
	input  logic                            in_valid,
	output logic                            in_stall,
	input  logic [crsfr_pkg::BYTE_W-1:0]    rx_byte,
	input  logic                            from_serial,
	output logic                            out_valid,
	input  logic                            out_stall,
	output logic                            accepted,
	output logic                            frame_done,
	output logic                            crc_error,
	output logic [crsfr_pkg::BYTE_W-1:0]    frame_type,
	output logic [crsfr_pkg::BYTE_W-1:0]    frame_length,
	output logic                            battery_seen,
	output logic                            baro_seen
);
	import crsfr_pkg::*;

	cfg_t    cfg;
	result_t res;
	result_t res_out;
	logic    buf_full;
	logic    take;

	// input word taken whenever the skid stage is free
	assign in_stall = buf_full;
	assign take     = in_valid && !buf_full;

	crsfr_cfg_regs u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cfg       (cfg)
	);

	crsfr_parser u_parser (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg         (cfg),
		.take        (take),
		.rx_byte     (rx_byte),
		.from_serial (from_serial),
		.result      (res)
	);

	crsfr_out_buf u_out (
		.clk       (clk),
		.arst_n    (arst_n),
		.wr        (take),
		.wr_data   (res),
		.full      (buf_full),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.out_data  (res_out)
	);

	// output word fields
	assign accepted     = res_out.accepted;
	assign frame_done   = res_out.frame_done;
	assign crc_error    = res_out.crc_error;
	assign frame_type   = res_out.frame_type;
	assign frame_length = res_out.frame_length;
	assign battery_seen = res_out.battery_seen;
	assign baro_seen    = res_out.baro_seen;

endmodule
